// ----- design/hrd_pkg.sv -----
// Shared types and constants for the hardware-monitor reading decoder.
// Used by every module of the block; depends on nothing else.
package hrd_pkg;

    typedef enum logic [2:0] {
        MODE_VOLT  = 3'd0,
        MODE_TEMP  = 3'd1,
        MODE_FAN   = 3'd2,
        MODE_RPM   = 3'd3,
        MODE_PWM   = 3'd4
    } mode_t;

    typedef enum logic [1:0] {
        CFG_MAX_FAN_COUNT  = 2'd0,
        CFG_MIN_FAN_COUNT  = 2'd1,
        CFG_MIN_DIRECT_RPM = 2'd2
    } cfg_idx_t;

    localparam int FAN_COUNT_W = 13;
    localparam int RPM_W       = 16;
    localparam int READING_W   = 17;

    // Register reset values.
    localparam logic [FAN_COUNT_W-1:0] MAX_FAN_RESET = 13'd8191;
    localparam logic [FAN_COUNT_W-1:0] MIN_FAN_RESET = 13'd21;
    localparam logic [RPM_W-1:0]       MIN_RPM_RESET = 16'd164;

    // Temperature window in half degrees.
    localparam logic signed [9:0] TEMP_MAX_HALF = 10'sd250;
    localparam logic signed [9:0] TEMP_MIN_HALF = -10'sd110;

    // Fan conversion: rpm = FAN_CLOCK_RPM / count, quotient kept to 16 bits.
    localparam int FAN_CLOCK_RPM = 1350000;
    localparam int DIV_QBITS     = RPM_W;
    localparam int DIV_LAST      = DIV_QBITS - 1;
    // Counts below this give a quotient that does not fit and saturate.
    localparam int FAN_SAT_COUNT = FAN_CLOCK_RPM / (2 ** DIV_QBITS) + 1;
    localparam logic [FAN_COUNT_W-1:0] FAN_SAT_CNT = FAN_COUNT_W'(FAN_SAT_COUNT);
    // Upper dividend bits preload the remainder; the low bits are shifted in.
    localparam logic [FAN_COUNT_W-1:0] DIV_REM_INIT =
        FAN_COUNT_W'(FAN_CLOCK_RPM / (2 ** DIV_QBITS));
    localparam logic [DIV_QBITS-1:0] DIV_LOW =
        DIV_QBITS'(FAN_CLOCK_RPM % (2 ** DIV_QBITS));
    localparam logic [RPM_W-1:0] RPM_SAT = '1;

    // PWM: hundredths of a percent = (duty * 10000 + 127) / 255.
    localparam int PWM_SCALE = 10000;
    localparam int PWM_DEN   = 255;
    localparam logic [5:0] PWM_INT   = 6'(PWM_SCALE / PWM_DEN);
    localparam logic [5:0] PWM_FRAC  = 6'(PWM_SCALE % PWM_DEN);
    localparam logic [6:0] PWM_ROUND = 7'(PWM_DEN / 2);

    // Queue between the classifier and the divider pipe.
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);

    typedef struct packed {
        logic                   div;      // reading comes from the divider
        logic [FAN_COUNT_W-1:0] divisor;
        logic [READING_W-1:0]   reading;
        logic                   status;
    } q_entry_t;

    typedef struct packed {
        q_entry_t               entry;
        logic [FAN_COUNT_W-1:0] rem;
        logic [DIV_QBITS-1:0]   quo;
    } bk_stage_t;

endpackage

// ----- design/hrd_front.sv -----
// Front end of the reading decoder: configuration registers, input transfer
// and classification of each item into a finished reading or a fan division.
// Depends on hrd_pkg.
module hrd_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [23:0]         s_tdata,
    input  logic [2:0]          s_tuser,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [15:0]         cfg_data,
    input  logic                q_full,
    output logic                q_push,
    output hrd_pkg::q_entry_t   q_entry
);

    logic [hrd_pkg::FAN_COUNT_W-1:0] max_fan_reg;
    logic [hrd_pkg::FAN_COUNT_W-1:0] min_fan_reg;
    logic [hrd_pkg::RPM_W-1:0]       min_rpm_reg;

    logic [7:0]                      high_byte;
    logic [7:0]                      low_byte;
    logic [2:0]                      half_bit_pos;
    logic                            half_bit_used;
    logic                            is_battery;
    logic                            battery_monitor_on;
    logic                            half_bit;
    logic signed [9:0]               temp_half;
    logic [hrd_pkg::FAN_COUNT_W-1:0] fan_count;
    logic [hrd_pkg::RPM_W-1:0]       direct_rpm;
    logic [13:0]                     pwm_int;
    logic [13:0]                     pwm_frac;
    logic [14:0]                     pwm_sum;
    logic [6:0]                      pwm_q;
    logic [13:0]                     pwm_duty;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_fan_reg <= hrd_pkg::MAX_FAN_RESET;
            min_fan_reg <= hrd_pkg::MIN_FAN_RESET;
            min_rpm_reg <= hrd_pkg::MIN_RPM_RESET;
        end
        else if (cfg_valid)
        begin
            case (hrd_pkg::cfg_idx_t'(cfg_index))
                hrd_pkg::CFG_MAX_FAN_COUNT:  max_fan_reg <= cfg_data[12:0];
                hrd_pkg::CFG_MIN_FAN_COUNT:  min_fan_reg <= cfg_data[12:0];
                hrd_pkg::CFG_MIN_DIRECT_RPM: min_rpm_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    assign high_byte          = s_tdata[7:0];
    assign low_byte           = s_tdata[15:8];
    assign half_bit_pos       = s_tdata[18:16];
    assign half_bit_used      = s_tdata[19];
    assign is_battery         = s_tdata[20];
    assign battery_monitor_on = s_tdata[21];

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;

    assign half_bit   = half_bit_used & low_byte[half_bit_pos];
    assign temp_half  = $signed({high_byte[7], high_byte, 1'b0})
                      + $signed({9'd0, half_bit});
    assign fan_count  = {high_byte, low_byte[4:0]};
    assign direct_rpm = {high_byte, low_byte};

    // The scale is split into 39 * 255 + 55 so that only a small remainder
    // needs the divide by 255, done as (y + (y >> 8) + 1) >> 8.
    assign pwm_int  = 14'(high_byte * hrd_pkg::PWM_INT);
    assign pwm_frac = 14'(high_byte * hrd_pkg::PWM_FRAC) + 14'(hrd_pkg::PWM_ROUND);
    assign pwm_sum  = {1'b0, pwm_frac} + 15'(pwm_frac[13:8]) + 15'd1;
    assign pwm_q    = pwm_sum[14:8];
    assign pwm_duty = pwm_int + 14'(pwm_q);

    always_comb
    begin
        q_entry         = '0;
        q_entry.status  = 1'b1;
        q_entry.divisor = fan_count;
        case (hrd_pkg::mode_t'(s_tuser))
            hrd_pkg::MODE_VOLT:
            begin
                if (high_byte != 8'd0 && (!is_battery || battery_monitor_on))
                begin
                    q_entry.reading = {6'd0, high_byte, 3'd0};
                    q_entry.status  = 1'b0;
                end
            end
            hrd_pkg::MODE_TEMP:
            begin
                if (temp_half <= hrd_pkg::TEMP_MAX_HALF
                    && temp_half >= hrd_pkg::TEMP_MIN_HALF)
                begin
                    q_entry.reading = {{7{temp_half[9]}}, temp_half};
                    q_entry.status  = 1'b0;
                end
            end
            hrd_pkg::MODE_FAN:
            begin
                if (fan_count >= max_fan_reg)
                begin
                    q_entry.status = 1'b0;
                end
                else if (fan_count >= min_fan_reg)
                begin
                    q_entry.status = 1'b0;
                    if (fan_count < hrd_pkg::FAN_SAT_CNT)
                    begin
                        q_entry.reading = {1'b0, hrd_pkg::RPM_SAT};
                    end
                    else
                    begin
                        q_entry.div = 1'b1;
                    end
                end
            end
            hrd_pkg::MODE_RPM:
            begin
                q_entry.status = 1'b0;
                if (direct_rpm > min_rpm_reg)
                begin
                    q_entry.reading = {1'b0, direct_rpm};
                end
            end
            hrd_pkg::MODE_PWM:
            begin
                q_entry.status  = 1'b0;
                q_entry.reading = {3'd0, pwm_duty};
            end
            default:
            begin
            end
        endcase
    end

endmodule

// ----- design/hrd_queue.sv -----
// Short FIFO between the classifier and the divider pipe.
// Register based; depends on hrd_pkg for the entry type and depth.
module hrd_queue
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  hrd_pkg::q_entry_t push_entry,
    output logic              full,
    input  logic              pop,
    output hrd_pkg::q_entry_t head,
    output logic              empty
);

    hrd_pkg::q_entry_t              entry_reg [hrd_pkg::Q_DEPTH];
    logic [hrd_pkg::Q_PTR_W-1:0]    wr_ptr_reg;
    logic [hrd_pkg::Q_PTR_W-1:0]    wr_ptr_next;
    logic [hrd_pkg::Q_PTR_W-1:0]    rd_ptr_reg;
    logic [hrd_pkg::Q_PTR_W-1:0]    rd_ptr_next;
    logic [hrd_pkg::Q_PTR_W:0]      count_reg;
    logic [hrd_pkg::Q_PTR_W:0]      count_next;

    assign full  = count_reg == (hrd_pkg::Q_PTR_W + 1)'(hrd_pkg::Q_DEPTH);
    assign empty = count_reg == '0;
    assign head  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// ----- design/hrd_back.sv -----
// Back end of the reading decoder: a restoring divider pipe, one quotient
// bit per stage, that every item passes through in order; the last stage is
// the output register. Depends on hrd_pkg.
module hrd_back
(
    input  logic              clk,
    input  logic              rst_n,
    input  hrd_pkg::q_entry_t head,
    input  logic              q_empty,
    output logic              q_pop,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [23:0]       m_tdata,
    output logic              m_tuser
);

    hrd_pkg::bk_stage_t stage_reg [hrd_pkg::DIV_QBITS];
    hrd_pkg::bk_stage_t stage_in  [hrd_pkg::DIV_QBITS];
    hrd_pkg::bk_stage_t stage_next[hrd_pkg::DIV_QBITS];
    logic               valid_reg [hrd_pkg::DIV_QBITS];
    logic               valid_in  [hrd_pkg::DIV_QBITS];
    logic               advance;

    // The whole pipe moves unless the output register holds a result that
    // is not taken.
    assign advance = !valid_reg[hrd_pkg::DIV_LAST] || m_tready;
    assign q_pop   = advance && !q_empty;

    always_comb
    begin
        stage_in[0].entry = head;
        stage_in[0].rem   = hrd_pkg::DIV_REM_INIT;
        stage_in[0].quo   = '0;
        valid_in[0]       = !q_empty;
    end

    for (genvar i = 0; i < hrd_pkg::DIV_QBITS; i++)
    begin : g_stage
        logic [hrd_pkg::FAN_COUNT_W:0] trial;
        logic                          fits;

        if (i > 0)
        begin : g_link
            assign stage_in[i] = stage_reg[i-1];
            assign valid_in[i] = valid_reg[i-1];
        end

        assign trial = {stage_in[i].rem, hrd_pkg::DIV_LOW[hrd_pkg::DIV_LAST-i]};
        assign fits  = trial >= {1'b0, stage_in[i].entry.divisor};

        always_comb
        begin
            stage_next[i]       = stage_in[i];
            stage_next[i].quo   = {stage_in[i].quo[hrd_pkg::DIV_QBITS-2:0], fits};
            stage_next[i].rem   = fits
                ? hrd_pkg::FAN_COUNT_W'(trial - {1'b0, stage_in[i].entry.divisor})
                : trial[hrd_pkg::FAN_COUNT_W-1:0];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[i] <= 1'b0;
            end
            else if (advance)
            begin
                valid_reg[i] <= valid_in[i];
            end
        end

        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                stage_reg[i] <= stage_next[i];
            end
        end
    end

    assign m_tvalid = valid_reg[hrd_pkg::DIV_LAST];
    assign m_tuser  = stage_reg[hrd_pkg::DIV_LAST].entry.status;
    assign m_tdata  = stage_reg[hrd_pkg::DIV_LAST].entry.div
        ? {8'd0, stage_reg[hrd_pkg::DIV_LAST].quo}
        : {7'd0, stage_reg[hrd_pkg::DIV_LAST].entry.reading};

endmodule

// ----- design/hwmon_reading_decoder_top.sv -----
// Top level of the hardware-monitor reading decoder.
// Instantiates hrd_front, hrd_queue and hrd_back; depends on hrd_pkg.
//
// Channel   Direction  Transfer when           Payload
// s_*       in         s_tvalid & s_tready     raw register bytes, mode in s_tuser
// m_*       out        m_tvalid & m_tready     reading in m_tdata, status in m_tuser
// cfg_*     in         cfg_valid & cfg_ready   register index and write data
//
// One item is accepted per cycle and one result leaves per cycle when both
// sides keep flowing. Each item passes through the queue and then through the
// divider pipe, one quotient bit per stage, that all items share.
// Reset clears the queue, the pipe valid bits and loads the register defaults.
// A stalled output freezes the pipe; the 4-entry queue then fills and drops
// s_tready.
module hwmon_reading_decoder_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [7:0] high_byte, [15:8] low_byte, [18:16] half_bit_pos,
    // [19] half_bit_used, [20] is_battery, [21] battery_monitor_on
    input  logic [23:0] s_tdata,
    // [2:0] mode
    input  logic [2:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [16:0] reading (signed)
    output logic [23:0] m_tdata,
    // [0] status
    output logic        m_tuser,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    hrd_pkg::q_entry_t push_entry;
    hrd_pkg::q_entry_t head;
    logic              q_push;
    logic              q_full;
    logic              q_pop;
    logic              q_empty;

    hrd_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_entry   (push_entry)
    );

    hrd_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (q_pop),
        .head       (head),
        .empty      (q_empty)
    );

    hrd_back u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head),
        .q_empty  (q_empty),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

// ----- tb/tb.sv -----
// Self-checking testbench for hwmon_reading_decoder_top: directed sensor readings,
// then random ones under several limit settings, each checked against its typed reading or a local decoder.
// Depends on hrd_pkg and the block's RTL only.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] MODE_UNUSED_LO = 3'd5;
    localparam logic [2:0] MODE_UNUSED_HI = 3'd7;
    localparam int TEMP_HI_HALF   = 250;
    localparam int TEMP_LO_HALF   = -110;
    localparam int FAN_TACH_RPM   = 1350000;
    localparam int RPM_CEIL       = 65535;
    localparam int PIPE_LATENCY   = 17;
    localparam int STALL_CYCLES   = 200;
    localparam int QUIET_LIMIT    = 2000;
    localparam int NUM_PHASES     = 6;
    localparam int RAND_PER_PHASE = 105;
    localparam int NUM_DIRECTED   = 26;

    typedef struct {
        logic [2:0] mode;
        logic [7:0] hi;
        logic [7:0] lo;
        logic [2:0] pos;
        logic       used;
        logic       bat;
        logic       bat_on;
    } sensor_item_t;

    typedef struct packed {
        logic signed [16:0] reading;
        logic               status;
    } readout_t;

    typedef struct {
        sensor_item_t       item;
        logic               typed;
        logic signed [16:0] reading;
        logic               status;
    } row_t;

    // Rows with typed=1 carry their expected reading; the others use the decoder.
    row_t directed_rows [NUM_DIRECTED] = '{
        '{'{hrd_pkg::MODE_VOLT, 8'h00, 8'h00, 3'd0, 1'b0, 1'b0, 1'b0}, 1'b1, 0, 1'b1},
        '{'{hrd_pkg::MODE_VOLT, 8'hFF, 8'h00, 3'd0, 1'b0, 1'b0, 1'b0}, 1'b1, 2040, 1'b0},
        '{'{hrd_pkg::MODE_VOLT, 8'h64, 8'hFF, 3'd7, 1'b1, 1'b1, 1'b0}, 1'b1, 0, 1'b1},
        '{'{hrd_pkg::MODE_VOLT, 8'h01, 8'h00, 3'd0, 1'b0, 1'b1, 1'b1}, 1'b1, 8, 1'b0},
        // A half bit at position zero pushes 125 C just past the window.
        '{'{hrd_pkg::MODE_TEMP, 8'h7D, 8'h01, 3'd0, 1'b1, 1'b0, 1'b0}, 1'b1, 0, 1'b1},
        '{'{hrd_pkg::MODE_TEMP, 8'h7D, 8'hFE, 3'd0, 1'b1, 1'b0, 1'b0}, 1'b1, 250, 1'b0},
        '{'{hrd_pkg::MODE_TEMP, 8'hC9, 8'hFF, 3'd7, 1'b0, 1'b0, 1'b0}, 1'b1, -110, 1'b0},
        '{'{hrd_pkg::MODE_TEMP, 8'hC8, 8'h80, 3'd7, 1'b1, 1'b0, 1'b0}, 1'b1, 0, 1'b1},
        '{'{hrd_pkg::MODE_TEMP, 8'h80, 8'h00, 3'd0, 1'b0, 1'b0, 1'b0}, 1'b1, 0, 1'b1},
        '{'{hrd_pkg::MODE_TEMP, 8'h7F, 8'hFF, 3'd5, 1'b1, 1'b1, 1'b1}, 1'b1, 0, 1'b1},
        '{'{hrd_pkg::MODE_TEMP, 8'hFF, 8'h08, 3'd3, 1'b1, 1'b0, 1'b0}, 1'b1, -1, 1'b0},
        '{'{hrd_pkg::MODE_TEMP, 8'h32, 8'h40, 3'd6, 1'b1, 1'b0, 1'b0}, 1'b0, 0, 1'b0},
        '{'{hrd_pkg::MODE_FAN,  8'hFF, 8'h1F, 3'd0, 1'b0, 1'b0, 1'b0}, 1'b1, 0, 1'b0},
        '{'{hrd_pkg::MODE_FAN,  8'h00, 8'h00, 3'd0, 1'b0, 1'b0, 1'b0}, 1'b1, 0, 1'b1},
        '{'{hrd_pkg::MODE_FAN,  8'h00, 8'h14, 3'd0, 1'b0, 1'b0, 1'b0}, 1'b1, 0, 1'b1},
        '{'{hrd_pkg::MODE_FAN,  8'h00, 8'h15, 3'd0, 1'b0, 1'b0, 1'b0}, 1'b1, 64285, 1'b0},
        '{'{hrd_pkg::MODE_FAN,  8'h20, 8'hE0, 3'd0, 1'b0, 1'b0, 1'b0}, 1'b1, 1318, 1'b0},
        '{'{hrd_pkg::MODE_FAN,  8'h5A, 8'h0B, 3'd2, 1'b1, 1'b1, 1'b0}, 1'b0, 0, 1'b0},
        '{'{hrd_pkg::MODE_RPM,  8'h00, 8'hA4, 3'd0, 1'b0, 1'b0, 1'b0}, 1'b1, 0, 1'b0},
        '{'{hrd_pkg::MODE_RPM,  8'h00, 8'hA5, 3'd0, 1'b0, 1'b0, 1'b0}, 1'b1, 165, 1'b0},
        '{'{hrd_pkg::MODE_RPM,  8'hFF, 8'hFF, 3'd0, 1'b0, 1'b0, 1'b0}, 1'b1, 65535, 1'b0},
        '{'{hrd_pkg::MODE_PWM,  8'h00, 8'h00, 3'd0, 1'b0, 1'b0, 1'b0}, 1'b1, 0, 1'b0},
        '{'{hrd_pkg::MODE_PWM,  8'hFF, 8'h00, 3'd0, 1'b0, 1'b0, 1'b0}, 1'b1, 10000, 1'b0},
        '{'{hrd_pkg::MODE_PWM,  8'h01, 8'h00, 3'd0, 1'b0, 1'b0, 1'b0}, 1'b0, 0, 1'b0},
        '{'{MODE_UNUSED_LO, 8'h10, 8'h10, 3'd0, 1'b0, 1'b0, 1'b0}, 1'b1, 0, 1'b1},
        '{'{MODE_UNUSED_HI, 8'hFF, 8'hFF, 3'd7, 1'b1, 1'b1, 1'b1}, 1'b1, 0, 1'b1}
    };

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;
    logic [2:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;
    logic        m_tuser;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;

    // Local copies of the limit registers.
    logic [12:0] max_fan_cnt = 13'd8191;
    logic [12:0] min_fan_cnt = 13'd21;
    logic [15:0] min_rpm     = 16'd164;

    readout_t pending_readings [$];
    int       mismatches   = 0;
    int       invalid_seen = 0;
    int       items_sent   = 0;
    int       mode_seen [8];
    int       quiet_cycles = 0;
    bit       burst        = 1'b0;
    bit       hold_start   = 1'b0;
    bit       hold_done    = 1'b0;

    hwmon_reading_decoder_top i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic readout_t decode_reading(input sensor_item_t it);
        readout_t    r;
        int          t;
        int unsigned cnt;
        int unsigned v;
        r.reading = '0;
        r.status  = 1'b1;
        case (it.mode)
            hrd_pkg::MODE_VOLT:
            begin
                if (it.hi != 8'd0 && (!it.bat || it.bat_on))
                begin
                    r.reading = 17'(int'(it.hi) * 8);
                    r.status  = 1'b0;
                end
            end
            hrd_pkg::MODE_TEMP:
            begin
                t = int'(it.hi);
                if (it.hi[7])
                    t = t - 256;
                t = 2 * t;
                if (it.used)
                    t = t + int'(it.lo[it.pos]);
                if (t <= TEMP_HI_HALF && t >= TEMP_LO_HALF)
                begin
                    r.reading = 17'(t);
                    r.status  = 1'b0;
                end
            end
            hrd_pkg::MODE_FAN:
            begin
                cnt = {it.hi, it.lo[4:0]};
                if (cnt >= max_fan_cnt)
                    r.status = 1'b0;
                else if (cnt >= min_fan_cnt)
                begin
                    // A zero count or a quotient past 16 bits saturates.
                    v = (cnt == 0) ? RPM_CEIL : FAN_TACH_RPM / cnt;
                    if (v > RPM_CEIL)
                        v = RPM_CEIL;
                    r.reading = 17'(v);
                    r.status  = 1'b0;
                end
            end
            hrd_pkg::MODE_RPM:
            begin
                v = {it.hi, it.lo};
                r.reading = (v > min_rpm) ? 17'(v) : 17'd0;
                r.status  = 1'b0;
            end
            hrd_pkg::MODE_PWM:
            begin
                r.reading = 17'((int'(it.hi) * 10000 + 127) / 255);
                r.status  = 1'b0;
            end
            default:
                r.status = 1'b1;
        endcase
        return r;
    endfunction

    // Biased toward the window edges, the count limits and the saturation range.
    function automatic sensor_item_t random_item();
        sensor_item_t it;
        int           k;
        logic [12:0]  cnt;
        logic [15:0]  v;
        it.hi     = 8'($urandom);
        it.lo     = 8'($urandom);
        it.pos    = 3'($urandom);
        it.used   = 1'($urandom);
        it.bat    = 1'($urandom);
        it.bat_on = 1'($urandom);
        k = $urandom_range(99);
        it.mode = (k < 5) ? 3'(MODE_UNUSED_LO + $urandom_range(2)) : 3'($urandom_range(4));
        k = $urandom_range(99);
        case (it.mode)
            hrd_pkg::MODE_VOLT:
            begin
                if (k < 10)
                    it.hi = 8'd0;
            end
            hrd_pkg::MODE_TEMP:
            begin
                if (k < 20)
                    it.hi = 8'(124 + $urandom_range(2));
                else if (k < 40)
                    it.hi = 8'(-56 + int'($urandom_range(2)));
            end
            hrd_pkg::MODE_FAN:
            begin
                if (k < 25)
                    cnt = 13'($urandom_range(40));
                else if (k < 35)
                    cnt = 13'(int'(max_fan_cnt) + int'($urandom_range(4)) - 2);
                else if (k < 45)
                    cnt = 13'(int'(min_fan_cnt) + int'($urandom_range(4)) - 2);
                else
                    cnt = 13'($urandom);
                it.hi = cnt[12:5];
                it.lo = {it.lo[7:5], cnt[4:0]};
            end
            hrd_pkg::MODE_RPM:
            begin
                if (k < 30)
                begin
                    v = 16'(int'(min_rpm) + int'($urandom_range(4)) - 2);
                    it.hi = v[15:8];
                    it.lo = v[7:0];
                end
            end
            default:
            begin
            end
        endcase
        return it;
    endfunction

    task automatic report_mismatch(input string what, input logic [23:0] got,
                                   input logic [23:0] want);
        $display("MISMATCH %s: got 0x%0h, expected 0x%0h at %0t", what, got, want, $time);
        mismatches++;
    endtask

    // Entered just after a falling edge; leaves s_tvalid high for the next item.
    task automatic send_item(input sensor_item_t it, input logic typed, input readout_t want);
        while (!burst && $urandom_range(99) < 6)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, it.bat_on, it.bat, it.used, it.pos, it.lo, it.hi};
        s_tuser  <= it.mode;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pending_readings.push_back(typed ? want : decode_reading(it));
        mode_seen[it.mode]++;
        items_sent++;
        @(negedge clk);
    endtask

    task automatic set_limits(input logic [15:0] max_v, input logic [15:0] min_v,
                              input logic [15:0] rpm_v);
        logic [15:0]       vals [3];
        hrd_pkg::cfg_idx_t regs [3];
        vals = '{max_v, min_v, rpm_v};
        regs = '{hrd_pkg::CFG_MAX_FAN_COUNT, hrd_pkg::CFG_MIN_FAN_COUNT,
                 hrd_pkg::CFG_MIN_DIRECT_RPM};
        for (int i = 0; i < 3; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= regs[i];
            cfg_data  <= vals[i];
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
            case (regs[i])
                hrd_pkg::CFG_MAX_FAN_COUNT:  max_fan_cnt = vals[i][12:0];
                hrd_pkg::CFG_MIN_FAN_COUNT:  min_fan_cnt = vals[i][12:0];
                hrd_pkg::CFG_MIN_DIRECT_RPM: min_rpm     = vals[i];
                default:
                begin
                end
            endcase
            @(negedge clk);
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        @(posedge clk);
        while (pending_readings.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Result side: random idling, one long hold while the sender keeps going.
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_start && !hold_done)
            begin
                hold_done = 1'b1;
                m_tready <= 1'b0;
                repeat (STALL_CYCLES - 1)
                    @(negedge clk);
            end
            else
                m_tready <= burst || ($urandom_range(99) >= 6);
        end
    end

    always @(posedge clk)
    begin : check_result
        readout_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (m_tuser)
                invalid_seen++;
            if (pending_readings.size() == 0)
                report_mismatch("result with nothing pending", m_tdata, 24'd0);
            else
            begin
                want = pending_readings.pop_front();
                if (m_tdata !== {7'd0, want.reading})
                    report_mismatch("reading", m_tdata, {7'd0, want.reading});
                if (m_tuser !== want.status)
                    report_mismatch("status", {23'd0, m_tuser}, {23'd0, want.status});
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Timeout: no transfer for %0d cycles", QUIET_LIMIT);
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        int unsigned top_cnt;
        readout_t    no_want;
        no_want   = '0;
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        repeat (8)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed rows run on the reset values of the limits.
        for (int r = 0; r < NUM_DIRECTED; r++)
            send_item(directed_rows[r].item, directed_rows[r].typed,
                      '{directed_rows[r].reading, directed_rows[r].status});
        s_tvalid <= 1'b0;
        drain();

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            case (p)
                0: set_limits(16'd0, 16'd0, 16'd0);
                1: set_limits(16'd8191, 16'd0, 16'hFFFF);
                2: set_limits(16'd8191, 16'd8191, 16'd0);
                3: set_limits(16'($urandom), 16'($urandom), 16'($urandom));
                4:
                begin
                    top_cnt = $urandom_range(8191);
                    set_limits(16'(top_cnt), 16'($urandom_range(top_cnt)),
                               16'($urandom_range(1000)));
                end
                default: set_limits(16'd8191, 16'd21, 16'd164);
            endcase
            burst = (p == 1);
            for (int n = 0; n < RAND_PER_PHASE; n++)
            begin
                if (p == 3 && n == 40)
                    hold_start = 1'b1;
                send_item(random_item(), 1'b0, no_want);
            end
            s_tvalid <= 1'b0;
            drain();
        end

        repeat (2 * PIPE_LATENCY)
            @(posedge clk);
        $display("Covered %0d sensor items over %0d limit settings; %0d readings were invalid.",
                 items_sent, NUM_PHASES + 1, invalid_seen);
        $display("Items by mode (volt temp fan rpm pwm unused): %0d %0d %0d %0d %0d %0d",
                 mode_seen[0], mode_seen[1], mode_seen[2], mode_seen[3], mode_seen[4],
                 mode_seen[5] + mode_seen[6] + mode_seen[7]);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
